// ===== sv/srle_pkg.sv =====
package srle_pkg;

  // Widths of the code builder: a pending code never reaches 0x40, a finished one stays below 0x400
  localparam int ACC_W  = 6;
  localparam int CODE_W = 10;
  localparam int RUN_W  = 8;

  // Thresholds that end a code after one, two or three nibbles
  localparam logic [CODE_W-1:0] THR_ONE   = 10'h004;
  localparam logic [CODE_W-1:0] THR_TWO   = 10'h010;
  localparam logic [CODE_W-1:0] THR_THREE = 10'h040;

  // Nibble counts of the pending code
  localparam logic [1:0] CNT_NONE  = 2'd0;
  localparam logic [1:0] CNT_ONE   = 2'd1;
  localparam logic [1:0] CNT_TWO   = 2'd2;
  localparam logic [1:0] CNT_THREE = 2'd3;

  // Configuration register indexes
  localparam logic REG_LINE_WIDTH = 1'b0;
  localparam logic REG_FIELD_ROWS = 1'b1;

  localparam int CFG_W = 13;

  // Reset values of the configuration registers
  localparam logic [12:0] LINE_WIDTH_RST = 13'd720;
  localparam logic [10:0] FIELD_ROWS_RST = 11'd240;

  typedef struct packed {
    logic [ACC_W-1:0] accum;
    logic [1:0]       cnt;
  } code_st_t;

  typedef struct packed {
    logic [1:0]  run_color;
    logic [12:0] run_length;
    logic [11:0] start_x;
    logic [10:0] frame_row;
    logic        line_end;
    logic        field_done;
    logic        item_last;
  } run_t;

endpackage

// ===== sv/srle_nib_step.sv =====
module srle_nib_step #(
  parameter int COL_W = 13,
  parameter int ROW_W = 11
) (
  input  logic                en,
  input  logic [3:0]          nib,
  input  logic                parity,
  input  srle_pkg::code_st_t  code_in,
  input  logic [COL_W-1:0]    col_in,
  input  logic [ROW_W-1:0]    row_in,
  input  logic [COL_W-1:0]    eff_w,
  input  logic [ROW_W-1:0]    eff_rows,
  output logic                emit,
  output srle_pkg::code_st_t  code_out,
  output logic [COL_W-1:0]    col_out,
  output logic [ROW_W-1:0]    row_out,
  output srle_pkg::run_t      res
);
  import srle_pkg::*;

  localparam int CMP_W = (COL_W > RUN_W) ? COL_W : RUN_W;

  logic [CODE_W-1:0] code;
  logic              done;
  logic [COL_W-1:0]  remaining;
  logic [RUN_W-1:0]  run_raw;
  logic              clip;
  logic [COL_W-1:0]  run_eff;
  logic [COL_W-1:0]  col_sum;
  logic              line;
  logic [ROW_W-1:0]  row_inc;
  logic              fdone;

  // Append the nibble and decide whether the code is complete
  assign code = {code_in.accum, nib};

  always_comb begin
    unique case (code_in.cnt)
      CNT_NONE:  done = (code >= THR_ONE);
      CNT_ONE:   done = (code >= THR_TWO);
      CNT_TWO:   done = (code >= THR_THREE);
      CNT_THREE: done = 1'b1;
      default:   done = 1'b1;
    endcase
  end

  // Clip the run to what is left of the line; a zero run fills the line
  assign remaining = (col_in < eff_w) ? (eff_w - col_in) : '0;
  assign run_raw   = code[CODE_W-1:2];
  assign clip      = (run_raw == '0) || (CMP_W'(run_raw) > CMP_W'(remaining));
  assign run_eff   = clip ? remaining : COL_W'(run_raw);
  assign col_sum   = col_in + run_eff;
  assign line      = (col_sum >= eff_w);
  assign row_inc   = row_in + 1'b1;
  assign fdone     = line && (row_inc >= eff_rows);

  // Advance the decoder state
  always_comb begin
    emit     = 1'b0;
    code_out = code_in;
    col_out  = col_in;
    row_out  = row_in;
    if (en) begin
      if (done) begin
        emit     = 1'b1;
        code_out = '0;
        col_out  = line ? '0 : col_sum;
        row_out  = line ? row_inc : row_in;
      end else begin
        code_out.accum = code[ACC_W-1:0];
        code_out.cnt   = code_in.cnt + 1'b1;
      end
    end
  end

  // Build the run descriptor
  always_comb begin
    res.run_color  = code[1:0];
    res.run_length = 13'(run_eff);
    res.start_x    = 12'(col_in);
    res.frame_row  = 11'({row_in, parity});
    res.line_end   = line;
    res.field_done = fdone;
    res.item_last  = 1'b0;
  end

endmodule

// ===== sv/subpicture_rle_field_decoder_core.sv =====
// Subpicture RLE field decoder: takes the RLE bytes of one interlaced field, high nibble first,
// and returns one run (color, length, start column, frame row, line-end and field-done flags)
// for every finished variable-length code. Raise in_field_start with the first byte of a field;
// before that, and after the last line of a field, bytes are taken and dropped. A byte is decoded
// in the cycle it is taken and its runs appear on the output in the next cycle. The next byte is
// taken once the buffer is empty or in the cycle that pops its last run, so a byte that yields
// two runs holds the input while the two-entry output buffer drains through the single result port
// one run per cycle while out_stall is low. Write the configuration only while the block is idle.
module subpicture_rle_field_decoder_core #(
  parameter int MAX_WIDTH      = 4096,
  parameter int MAX_FIELD_ROWS = 1024
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // configuration
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [srle_pkg::CFG_W-1:0] cfg_wdata,
  // input bytes
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                in_data_byte,
  input  logic                      in_field_start,
  input  logic                      in_bottom_field,
  // runs
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                out_run_color,
  output logic [12:0]               out_run_length,
  output logic [11:0]               out_start_x,
  output logic [10:0]               out_frame_row,
  output logic                      out_line_end,
  output logic                      out_field_done,
  output logic                      out_item_last
);
  import srle_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W = $clog2(MAX_FIELD_ROWS + 1);

  logic [12:0]      line_width_r;
  logic [10:0]      field_rows_r;
  code_st_t         code_r;
  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  logic             parity_r;
  logic             fin_r;
  run_t             slot0_r, slot1_r;
  logic [1:0]       cnt_r;

  logic [COL_W-1:0] eff_w;
  logic [ROW_W-1:0] eff_rows;
  logic             in_acc;
  logic             out_pop;
  code_st_t         code_pre;
  logic [COL_W-1:0] col_pre;
  logic [ROW_W-1:0] row_pre;
  logic             parity_pre;
  logic             fin_pre;
  logic             en_a, en_b;
  logic             emit_a, emit_b;
  code_st_t         code_a, code_b;
  logic [COL_W-1:0] col_a, col_b;
  logic [ROW_W-1:0] row_a, row_b;
  run_t             res_a, res_b;
  run_t             res_a_last, res_b_last;

  // Clamp the configured sizes
  always_comb begin
    if (line_width_r == '0) begin
      eff_w = COL_W'(1);
    end else if (line_width_r > 13'(MAX_WIDTH)) begin
      eff_w = COL_W'(MAX_WIDTH);
    end else begin
      eff_w = COL_W'(line_width_r);
    end
    if (field_rows_r == '0) begin
      eff_rows = ROW_W'(1);
    end else if (field_rows_r > 11'(MAX_FIELD_ROWS)) begin
      eff_rows = ROW_W'(MAX_FIELD_ROWS);
    end else begin
      eff_rows = ROW_W'(field_rows_r);
    end
  end

  // Handshakes: take an item only when the buffer is empty after this cycle's pop
  assign out_valid = (cnt_r != 2'd0);
  assign out_pop   = out_valid && !out_stall;
  assign in_stall  = (cnt_r != 2'd0) && !((cnt_r == 2'd1) && !out_stall);
  assign in_acc    = in_valid && !in_stall;

  // Apply a field start before the byte
  always_comb begin
    code_pre   = code_r;
    col_pre    = col_r;
    row_pre    = row_r;
    parity_pre = parity_r;
    fin_pre    = fin_r;
    if (in_field_start) begin
      code_pre   = '0;
      col_pre    = '0;
      row_pre    = '0;
      parity_pre = in_bottom_field;
      fin_pre    = 1'b0;
    end
  end

  assign en_a = !fin_pre;

  srle_nib_step #(.COL_W(COL_W), .ROW_W(ROW_W)) u_step_hi (
    .en       (en_a),
    .nib      (in_data_byte[7:4]),
    .parity   (parity_pre),
    .code_in  (code_pre),
    .col_in   (col_pre),
    .row_in   (row_pre),
    .eff_w    (eff_w),
    .eff_rows (eff_rows),
    .emit     (emit_a),
    .code_out (code_a),
    .col_out  (col_a),
    .row_out  (row_a),
    .res      (res_a)
  );

  // Drop the low nibble when the high nibble ended the line
  assign en_b = en_a && !(emit_a && res_a.line_end);

  srle_nib_step #(.COL_W(COL_W), .ROW_W(ROW_W)) u_step_lo (
    .en       (en_b),
    .nib      (in_data_byte[3:0]),
    .parity   (parity_pre),
    .code_in  (code_a),
    .col_in   (col_a),
    .row_in   (row_a),
    .eff_w    (eff_w),
    .eff_rows (eff_rows),
    .emit     (emit_b),
    .code_out (code_b),
    .col_out  (col_b),
    .row_out  (row_b),
    .res      (res_b)
  );

  always_comb begin
    res_a_last           = res_a;
    res_a_last.item_last = !emit_b;
    res_b_last           = res_b;
    res_b_last.item_last = 1'b1;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= LINE_WIDTH_RST;
      field_rows_r <= FIELD_ROWS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LINE_WIDTH: line_width_r <= cfg_wdata[12:0];
        REG_FIELD_ROWS: field_rows_r <= cfg_wdata[10:0];
        default: ;
      endcase
    end
  end

  // Decoder state: advance on every taken item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_r   <= '0;
      col_r    <= '0;
      row_r    <= '0;
      parity_r <= 1'b0;
      fin_r    <= 1'b1;
    end else if (in_acc) begin
      code_r   <= code_b;
      col_r    <= col_b;
      row_r    <= row_b;
      parity_r <= parity_pre;
      fin_r    <= fin_pre || (emit_a && res_a.field_done) || (emit_b && res_b.field_done);
    end
  end

  // Output buffer count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (in_acc) begin
      cnt_r <= {1'b0, emit_a} + {1'b0, emit_b};
    end else if (out_pop) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  // Output buffer payload: load on a taken item, shift on a pop
  always_ff @(posedge clk) begin
    if (in_acc) begin
      slot0_r <= emit_a ? res_a_last : res_b_last;
      slot1_r <= res_b_last;
    end else if (out_pop) begin
      slot0_r <= slot1_r;
    end
  end

  assign out_run_color  = slot0_r.run_color;
  assign out_run_length = slot0_r.run_length;
  assign out_start_x    = slot0_r.start_x;
  assign out_frame_row  = slot0_r.frame_row;
  assign out_line_end   = slot0_r.line_end;
  assign out_field_done = slot0_r.field_done;
  assign out_item_last  = slot0_r.item_last;

  // A completed field always completes its line
  a_done_has_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_field_done |-> out_line_end)
    else $error("field_done without line_end");

  // The first of two buffered runs is never the last of its item
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> !slot0_r.item_last)
    else $error("first of two runs marked last");

  // An idle byte leaves no run behind
  a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !in_field_start && fin_r |=> cnt_r == 2'd0)
    else $error("run produced while idle");

  // The buffer never holds more than two runs
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> cnt_r != 2'd3)
    else $error("output buffer overflow");

endmodule
